/* rtl/tle_pkg.sv */
// shared types, constants and helpers for the text line tab expander
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_SCROLL     = 2'd1;
  localparam logic [1:0] CFG_TAB_SIZE   = 2'd2;
  localparam logic [1:0] CFG_ENCODING   = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned SCROLL_W   = 12;

  // encoding codes
  localparam logic [1:0] ENC_ASCII = 2'd0;
  localparam logic [1:0] ENC_SJIS  = 2'd1;
  localparam logic [1:0] ENC_EUC   = 2'd2;

  // cell kinds
  localparam logic [1:0] KIND_SPACE  = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_PAIR   = 2'd2;

  // special bytes
  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_NL      = 8'h0a;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] SJIS_LO1     = 8'h81;
  localparam logic [7:0] SJIS_HI1     = 8'h9f;
  localparam logic [7:0] SJIS_LO2     = 8'he0;
  localparam logic [7:0] SJIS_HI2     = 8'hfc;
  localparam logic [7:0] EUC_LO       = 8'ha1;
  localparam logic [7:0] EUC_HI       = 8'hfe;

  localparam logic [6:0] WIDTH_MIN    = 7'd20;
  localparam logic [6:0] RST_WIDTH    = 7'd30;
  localparam logic [8:0] RST_TAB      = 9'd4;
  localparam logic [8:0] TAB_MAX      = 9'd256;

  typedef struct packed {
    logic [6:0]          line_width;
    logic [SCROLL_W-1:0] scroll_offset;
    logic [8:0]          tab_size;
    logic [1:0]          encoding;
  } tle_cfg_t;

  typedef struct packed {
    logic [6:0] cell_first;
    logic [6:0] cell_count;
    logic [1:0] cell_kind;
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic       line_end;
    logic       text_end;
    logic [6:0] line_length;
  } tle_cell_t;

  function automatic logic is_lead(input logic [7:0] b, input logic [1:0] enc);
    logic res;
    res = 1'b0;
    if (enc == ENC_SJIS) begin
      res = (b >= SJIS_LO1 && b <= SJIS_HI1) || (b >= SJIS_LO2 && b <= SJIS_HI2);
    end else if (enc == ENC_EUC) begin
      res = (b >= EUC_LO && b <= EUC_HI);
    end
    return res;
  endfunction

  // tab size as used: zero acts as one, anything above the max is clipped
  function automatic logic [8:0] eff_tab(input logic [8:0] t);
    logic [8:0] res;
    if (t == 9'd0) begin
      res = 9'd1;
    end else if (t > TAB_MAX) begin
      res = TAB_MAX;
    end else begin
      res = t;
    end
    return res;
  endfunction

  function automatic logic [7:0] phase_step(input logic [7:0] p, input logic [8:0] t);
    logic [8:0] p1;
    p1 = {1'b0, p} + 9'd1;
    return (p1 >= t) ? 8'd0 : p1[7:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/tle_byte_if.sv */
// input byte channel
`timescale 1ns / 1ps
`default_nettype none

interface tle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/tle_cell_if.sv */
// result channel carrying the visible cells written by one byte
`timescale 1ns / 1ps
`default_nettype none

interface tle_cell_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_first;
  logic [6:0] cell_count;
  logic [1:0] cell_kind;
  logic [7:0] char_first;
  logic [7:0] char_second;
  logic       line_end;
  logic       text_end;
  logic [6:0] line_length;

  modport source (output valid, output cell_first, output cell_count, output cell_kind,
                  output char_first, output char_second, output line_end,
                  output text_end, output line_length, input ready);
  modport sink (input valid, input cell_first, input cell_count, input cell_kind,
                input char_first, input char_second, input line_end,
                input text_end, input line_length, output ready);
endinterface

`default_nettype wire

/* rtl/tle_step.sv */
// per-byte placement logic: window clipping, tab fill, pair handling, next state
`timescale 1ns / 1ps
`default_nettype none

module tle_step import tle_pkg::*; #(
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned MAX_CELLS   = 128
) (
  input  logic [7:0]             in_byte_i,
  input  tle_cfg_t               cfg_i,
  input  logic [COLUMN_BITS-1:0] col_i,
  input  logic [7:0]             phase_i,
  input  logic                   lead_pend_i,
  input  logic [7:0]             lead_byte_i,
  output tle_cell_t              cell_o,
  output logic [COLUMN_BITS-1:0] col_o,
  output logic [7:0]             phase_o,
  output logic                   lead_pend_o,
  output logic [7:0]             lead_byte_o
);

  localparam int unsigned VW       = COLUMN_BITS + 2;
  localparam int unsigned WMAX_RAW = ((MAX_CELLS - 2) < 126) ? (MAX_CELLS - 2) : 126;
  localparam logic [6:0]  WMAX     = 7'(WMAX_RAW);

  function automatic logic [COLUMN_BITS-1:0] add_sat(input logic [COLUMN_BITS-1:0] c,
                                                     input logic [8:0] n);
    logic [COLUMN_BITS:0] sum;
    sum = {1'b0, c} + (COLUMN_BITS + 1)'(n);
    return sum[COLUMN_BITS] ? {COLUMN_BITS{1'b1}} : sum[COLUMN_BITS-1:0];
  endfunction

  logic [6:0]           w;
  logic [8:0]           t;
  logic [8:0]           tab_n;
  logic signed [VW-1:0] vis;
  logic signed [VW-1:0] ws;
  logic signed [VW-1:0] ws_m1;
  logic signed [VW-1:0] hi_raw;
  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] lo;
  logic signed [VW-1:0] span;
  logic                 is_end;

  always_comb begin
    if (cfg_i.line_width < WIDTH_MIN) begin
      w = WIDTH_MIN;
    end else if (cfg_i.line_width > WMAX) begin
      w = WMAX;
    end else begin
      w = cfg_i.line_width;
    end
  end

  assign t      = eff_tab(cfg_i.tab_size);
  // stale phase at or above the tab size advances a single column
  assign tab_n  = ({1'b0, phase_i} < t) ? (t - {1'b0, phase_i}) : 9'd1;
  assign vis    = $signed({2'b00, col_i}) -
                  $signed({{(VW - SCROLL_W){1'b0}}, cfg_i.scroll_offset});
  assign ws     = $signed({{(VW - 7){1'b0}}, w});
  assign ws_m1  = ws - $signed(VW'(1));
  assign hi_raw = vis + $signed({{(VW - 9){1'b0}}, tab_n});
  assign hi     = (hi_raw > ws) ? ws : hi_raw;
  assign lo     = (vis < 0) ? '0 : vis;
  assign span   = hi - lo;
  assign is_end = (in_byte_i == BYTE_NUL) || (in_byte_i == BYTE_NL);

  always_comb begin
    cell_o      = '0;
    col_o       = col_i;
    phase_o     = phase_i;
    lead_pend_o = lead_pend_i;
    lead_byte_o = lead_byte_i;
    priority if (is_end) begin
      cell_o.line_end = 1'b1;
      cell_o.text_end = (in_byte_i == BYTE_NUL);
      if (vis < 0) begin
        cell_o.line_length = 7'd0;
      end else if (vis > ws) begin
        cell_o.line_length = w;
      end else begin
        cell_o.line_length = vis[6:0];
      end
      col_o       = '0;
      phase_o     = '0;
      lead_pend_o = 1'b0;
      lead_byte_o = '0;
    end else if (lead_pend_i) begin
      // trail byte: pair drawn whole, one space where half clipped, nothing where fully outside
      if (vis == '1) begin
        cell_o.cell_count = 7'd1;
        cell_o.cell_kind  = KIND_SPACE;
        cell_o.char_first = BYTE_SPACE;
      end else if (vis >= 0 && vis < ws_m1) begin
        cell_o.cell_first  = vis[6:0];
        cell_o.cell_count  = 7'd2;
        cell_o.cell_kind   = KIND_PAIR;
        cell_o.char_first  = lead_byte_i;
        cell_o.char_second = in_byte_i;
      end else if (vis == ws_m1) begin
        cell_o.cell_first = vis[6:0];
        cell_o.cell_count = 7'd1;
        cell_o.cell_kind  = KIND_SPACE;
        cell_o.char_first = BYTE_SPACE;
      end
      col_o       = add_sat(col_i, 9'd2);
      phase_o     = phase_step(phase_step(phase_i, t), t);
      lead_pend_o = 1'b0;
    end else if (in_byte_i == BYTE_TAB) begin
      if (hi > lo) begin
        cell_o.cell_first = lo[6:0];
        cell_o.cell_count = span[6:0];
        cell_o.cell_kind  = KIND_SPACE;
        cell_o.char_first = BYTE_SPACE;
      end
      col_o   = add_sat(col_i, tab_n);
      phase_o = '0;
    end else if (is_lead(in_byte_i, cfg_i.encoding)) begin
      lead_pend_o = 1'b1;
      lead_byte_o = in_byte_i;
    end else begin
      if (vis >= 0 && vis < ws) begin
        cell_o.cell_first = vis[6:0];
        cell_o.cell_count = 7'd1;
        cell_o.cell_kind  = KIND_SINGLE;
        cell_o.char_first = in_byte_i;
      end
      col_o   = add_sat(col_i, 9'd1);
      phase_o = phase_step(phase_i, t);
    end
  end

endmodule

`default_nettype wire

/* rtl/text_line_tab_expander.sv */
// top level of the text line tab expander
//
//  channel  | dir | handshake      | payload
//  byte_i   | in  | valid / ready  | in_byte
//  cell_o   | out | valid / ready  | cell_first .. line_length, one result per byte
//  cfg_*    | in  | cfg_we_i       | cfg_idx_i selects register, cfg_wdata_i data
//
// one byte per cycle sustained while the result channel is not stalled; on the way
// bytes pass an input register, then the step logic fills the result register
// column, tab phase and held lead byte update in the same cycle as the result
// a stalled result holds the result register; the input register still takes one byte
// reset clears the control state and loads the register defaults, but not byte or cell data
`timescale 1ns / 1ps
`default_nettype none

module text_line_tab_expander import tle_pkg::*; #(
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned MAX_CELLS   = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tle_byte_if.sink              byte_i,
  tle_cell_if.source            cell_o
);

  tle_cfg_t               cfg_q;
  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   out_vld_q;
  tle_cell_t              cell_q;
  logic [COLUMN_BITS-1:0] col_q;
  logic [7:0]             phase_q;
  logic                   lead_pend_q;
  logic [7:0]             lead_byte_q;

  tle_cell_t              cell_d;
  logic [COLUMN_BITS-1:0] col_d;
  logic [7:0]             phase_d;
  logic                   lead_pend_d;
  logic [7:0]             lead_byte_d;
  logic                   adv;
  logic                   in_take;

  assign adv          = in_vld_q && (!out_vld_q || cell_o.ready);
  assign byte_i.ready = !in_vld_q || adv;
  assign in_take      = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width    <= RST_WIDTH;
      cfg_q.scroll_offset <= '0;
      cfg_q.tab_size      <= RST_TAB;
      cfg_q.encoding      <= ENC_ASCII;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_WIDTH: cfg_q.line_width    <= cfg_wdata_i[6:0];
        CFG_SCROLL:     cfg_q.scroll_offset <= cfg_wdata_i[SCROLL_W-1:0];
        CFG_TAB_SIZE:   cfg_q.tab_size      <= cfg_wdata_i[8:0];
        CFG_ENCODING:   cfg_q.encoding      <= cfg_wdata_i[1:0];
        default:        cfg_q               <= cfg_q;
      endcase
    end
  end

  tle_step #(
    .COLUMN_BITS(COLUMN_BITS),
    .MAX_CELLS  (MAX_CELLS)
  ) u_step (
    .in_byte_i  (in_byte_q),
    .cfg_i      (cfg_q),
    .col_i      (col_q),
    .phase_i    (phase_q),
    .lead_pend_i(lead_pend_q),
    .lead_byte_i(lead_byte_q),
    .cell_o     (cell_d),
    .col_o      (col_d),
    .phase_o    (phase_d),
    .lead_pend_o(lead_pend_d),
    .lead_byte_o(lead_byte_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      col_q       <= '0;
      phase_q     <= '0;
      lead_pend_q <= 1'b0;
      lead_byte_q <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q   <= 1'b1;
        col_q       <= col_d;
        phase_q     <= phase_d;
        lead_pend_q <= lead_pend_d;
        lead_byte_q <= lead_byte_d;
      end else if (cell_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.in_byte;
    end
    if (adv) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o.valid       = out_vld_q;
  assign cell_o.cell_first  = cell_q.cell_first;
  assign cell_o.cell_count  = cell_q.cell_count;
  assign cell_o.cell_kind   = cell_q.cell_kind;
  assign cell_o.char_first  = cell_q.char_first;
  assign cell_o.char_second = cell_q.char_second;
  assign cell_o.line_end    = cell_q.line_end;
  assign cell_o.text_end    = cell_q.text_end;
  assign cell_o.line_length = cell_q.line_length;

endmodule

`default_nettype wire

/* rtl/tle_checker.sv */
// port-level checks for the text line tab expander, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tle_checker import tle_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] cell_first,
  input wire logic [6:0] cell_count,
  input wire logic [1:0] cell_kind,
  input wire logic       line_end,
  input wire logic       text_end
);

  // a waiting result stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nul is always also a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && text_end |-> line_end)
    else $error("text end without line end");

  // line end draws nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && line_end |-> cell_count == 7'd0)
    else $error("cells written on line end");

  // written cells stay inside the widest window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ({1'b0, cell_first} + {1'b0, cell_count}) <= 8'd126)
    else $error("cells beyond the window");

  // a pair always covers two cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && cell_kind == KIND_PAIR |-> cell_count == 7'd2)
    else $error("pair with wrong cell count");

endmodule

bind text_line_tab_expander tle_checker u_tle_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (cell_o.valid),
  .out_ready (cell_o.ready),
  .cell_first(cell_o.cell_first),
  .cell_count(cell_o.cell_count),
  .cell_kind (cell_o.cell_kind),
  .line_end  (cell_o.line_end),
  .text_end  (cell_o.text_end)
);

`default_nettype wire
